// File: sv/rgb_led_strip_serial_driver_unit_defines.svh
// ---------------------------------------------------------------------------
// RGB LED strip serial driver: assertion macros
// Shared assertion wrappers, sampled on clk and quiet while rst is high
// where noted.
// ---------------------------------------------------------------------------
`ifndef RGB_LED_STRIP_SERIAL_DRIVER_UNIT_DEFINES_SVH
`define RGB_LED_STRIP_SERIAL_DRIVER_UNIT_DEFINES_SVH

// Property checked on every rising edge of clk, disabled during reset.
`define RGBSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Property checked on every rising edge of clk, reset included.
`define RGBSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error(msg);

`endif

// File: sv/rgbsd_pkg.sv
// ---------------------------------------------------------------------------
// RGB LED strip serial driver: package
// Action and register codes, reset values and the result record.
// ---------------------------------------------------------------------------
package rgbsd_pkg;

  localparam int NUM_LEDS_DEF = 9;
  localparam int CFG_W        = 16;

  typedef logic [1:0] action_t;
  localparam action_t ACT_SET     = 2'd0;
  localparam action_t ACT_REFRESH = 2'd1;
  localparam action_t ACT_TICK    = 2'd2;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_BIT_TICKS  = 2'd0;
  localparam cfg_idx_t CFG_ZERO_HIGH  = 2'd1;
  localparam cfg_idx_t CFG_ONE_HIGH   = 2'd2;
  localparam cfg_idx_t CFG_GAP_TICKS  = 2'd3;

  localparam logic [7:0]  BIT_TICKS_RST = 8'd10;
  localparam logic [7:0]  ZERO_HIGH_RST = 8'd3;
  localparam logic [7:0]  ONE_HIGH_RST  = 8'd6;
  localparam logic [15:0] GAP_TICKS_RST = 16'd400;

  // Byte order on the line within one LED.
  typedef logic [1:0] byte_sel_t;
  localparam byte_sel_t SEL_GREEN = 2'd0;
  localparam byte_sel_t SEL_RED   = 2'd1;
  localparam byte_sel_t SEL_BLUE  = 2'd2;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic rejected;
  } result_t;

endpackage

// File: sv/rgbsd_out_fifo.sv
// ---------------------------------------------------------------------------
// RGB LED strip serial driver: result queue
// Two-entry queue between the line coder and the result channel.
// ---------------------------------------------------------------------------
`include "rgb_led_strip_serial_driver_unit_defines.svh"

module rgbsd_out_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rgbsd_pkg::result_t push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output rgbsd_pkg::result_t out_data
);

  logic [1:0]         count;
  rgbsd_pkg::result_t slot0;
  rgbsd_pkg::result_t slot1;
  logic               pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_data  = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (count == 2'd1) begin
        slot0 <= push_data;
      end else begin
        slot0 <= slot1;
        slot1 <= push_data;
      end
    end else if (pop) begin
      slot0 <= slot1;
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= push_data;
      end else begin
        slot1 <= push_data;
      end
    end
  end

  `RGBSD_ASSERT(a_no_push_when_full, full |-> !push, "push into a full result queue")
  `RGBSD_ASSERT(a_pop_drains, (pop && !push) |=> (count == $past(count) - 2'd1),
    "result queue count did not drop after a transfer")

endmodule

// File: sv/rgb_led_strip_serial_driver_unit.sv
// ---------------------------------------------------------------------------
// RGB LED strip serial driver
// One-wire line coder for a strip of RGB LEDs with an on-chip colour store.
// ---------------------------------------------------------------------------
// Usage: each input transfer carries an action. A set-colour action writes
// one LED of the colour store, or every LED when led_index is at or beyond
// NUM_LEDS. A refresh action starts a frame, and every tick action then moves
// the data line by one time step: LEDs go out in order, green, red, blue,
// most significant bit first, each bit high for one_high_ticks or
// zero_high_ticks of a bit_ticks period, followed by a low latch gap of
// gap_ticks ticks. Set-colour and refresh are rejected while a frame or its
// gap is running. Timing registers are to be written by the user through
// cfg_we / cfg_index / cfg_data only while the block is idle; the block
// itself does not enforce this. Every input transfer gives exactly one
// result transfer. The block takes one item per clock while in_stall is
// low: the colour store is a synchronous RAM read at the next LED address
// each cycle, so the word is ready for the tick that needs it. A two-entry
// result queue lets input continue while one result waits; in_stall rises
// only when both entries are held because the receiver keeps out_stall high.
// Reset clears the store at once through per-LED valid bits and a fill word,
// so no clearing pass is needed and the block accepts items right after it.
// ---------------------------------------------------------------------------
`include "rgb_led_strip_serial_driver_unit_defines.svh"

module rgb_led_strip_serial_driver_unit #(
  parameter int NUM_LEDS = rgbsd_pkg::NUM_LEDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration port.
  input  logic                        cfg_we,
  input  rgbsd_pkg::cfg_idx_t         cfg_index,
  input  logic [rgbsd_pkg::CFG_W-1:0] cfg_data,
  // Input channel.
  input  logic                        in_valid,
  output logic                        in_stall,
  input  rgbsd_pkg::action_t          action,
  input  logic [7:0]                  led_index,
  input  logic [7:0]                  red,
  input  logic [7:0]                  green,
  input  logic [7:0]                  blue,
  // Result channel.
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        line_level,
  output logic                        busy_res,
  output logic                        frame_done,
  output logic                        rejected
);

  localparam int LED_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam logic [LED_W-1:0] LED_LAST  = LED_W'(NUM_LEDS - 1);
  localparam logic [8:0]       LED_COUNT = 9'(NUM_LEDS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEND = 2'd1;
  localparam logic [1:0] ST_GAP  = 2'd2;

  // Timing registers.
  logic [7:0]  bit_ticks;
  logic [7:0]  zero_high_ticks;
  logic [7:0]  one_high_ticks;
  logic [15:0] gap_ticks;

  // Coder state.
  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [LED_W-1:0]     led_ptr;
  logic [LED_W-1:0]     led_ptr_next;
  rgbsd_pkg::byte_sel_t byte_sel;
  rgbsd_pkg::byte_sel_t byte_sel_next;
  logic [2:0]           bit_pos;
  logic [2:0]           bit_pos_next;
  logic [7:0]           tick_in_bit;
  logic [7:0]           tick_in_bit_next;
  logic [15:0]          gap_count;
  logic [15:0]          gap_count_next;

  // Colour store: RAM plus per-LED valid bits and a fill word.
  logic [23:0]         colour_mem [NUM_LEDS];
  logic [NUM_LEDS-1:0] entry_valid;
  logic [23:0]         fill_word;
  logic [23:0]         rd_data;
  logic                rd_valid;
  logic                mem_we;
  logic                set_all;
  logic [LED_W-1:0]    wr_addr;

  logic               in_accept;
  logic               busy;
  logic               fifo_full;
  rgbsd_pkg::result_t res;
  rgbsd_pkg::result_t out_res;

  logic [23:0] led_word;
  logic [7:0]  cur_byte;
  logic        cur_bit;
  logic [7:0]  high_ticks;
  logic [7:0]  period;
  logic        bit_end;
  logic [15:0] gap_len;
  logic        gap_end;

  assign in_stall  = fifo_full;
  assign in_accept = in_valid && !in_stall;
  assign busy      = (state != ST_IDLE);
  assign wr_addr   = led_index[LED_W-1:0];

  // Current LED word: an entry not written since reset or the last broadcast reads as the fill word.
  assign led_word = rd_valid ? rd_data : fill_word;

  always_comb begin
    case (byte_sel)
      rgbsd_pkg::SEL_GREEN: cur_byte = led_word[15:8];
      rgbsd_pkg::SEL_RED:   cur_byte = led_word[23:16];
      default:              cur_byte = led_word[7:0];
    endcase
  end

  assign cur_bit    = cur_byte[3'd7 - bit_pos];
  assign high_ticks = cur_bit ? one_high_ticks : zero_high_ticks;
  // A period of zero behaves as one tick, and a gap of zero as one tick.
  assign period     = (bit_ticks == 8'd0) ? 8'd1 : bit_ticks;
  assign bit_end    = ({1'b0, tick_in_bit} + 9'd1) >= {1'b0, period};
  assign gap_len    = (gap_ticks == 16'd0) ? 16'd1 : gap_ticks;
  assign gap_end    = ({1'b0, gap_count} + 17'd1) >= {1'b0, gap_len};

  always_comb begin
    state_next       = state;
    led_ptr_next     = led_ptr;
    byte_sel_next    = byte_sel;
    bit_pos_next     = bit_pos;
    tick_in_bit_next = tick_in_bit;
    gap_count_next   = gap_count;
    mem_we           = 1'b0;
    set_all          = 1'b0;
    res              = '0;
    if (in_accept) begin
      case (action)
        rgbsd_pkg::ACT_SET: begin
          if (busy) begin
            res.rejected = 1'b1;
          end else if ({1'b0, led_index} < LED_COUNT) begin
            mem_we = 1'b1;
          end else begin
            set_all = 1'b1;
          end
        end
        rgbsd_pkg::ACT_REFRESH: begin
          if (busy) begin
            res.rejected = 1'b1;
          end else begin
            state_next       = ST_SEND;
            led_ptr_next     = '0;
            byte_sel_next    = rgbsd_pkg::SEL_GREEN;
            bit_pos_next     = 3'd0;
            tick_in_bit_next = 8'd0;
            gap_count_next   = 16'd0;
          end
        end
        rgbsd_pkg::ACT_TICK: begin
          if (state == ST_SEND) begin
            res.line_level = (tick_in_bit < high_ticks);
            if (bit_end) begin
              tick_in_bit_next = 8'd0;
              if (bit_pos == 3'd7) begin
                bit_pos_next = 3'd0;
                if (byte_sel == rgbsd_pkg::SEL_BLUE) begin
                  byte_sel_next = rgbsd_pkg::SEL_GREEN;
                  if (led_ptr == LED_LAST) begin
                    led_ptr_next   = '0;
                    state_next     = ST_GAP;
                    gap_count_next = 16'd0;
                  end else begin
                    led_ptr_next = led_ptr + LED_W'(1);
                  end
                end else begin
                  byte_sel_next = byte_sel + 2'd1;
                end
              end else begin
                bit_pos_next = bit_pos + 3'd1;
              end
            end else begin
              tick_in_bit_next = tick_in_bit + 8'd1;
            end
          end else if (state == ST_GAP) begin
            if (gap_end) begin
              gap_count_next = 16'd0;
              state_next     = ST_IDLE;
              res.frame_done = 1'b1;
            end else begin
              gap_count_next = gap_count + 16'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    res.busy_res = (state_next != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      led_ptr     <= '0;
      byte_sel    <= rgbsd_pkg::SEL_GREEN;
      bit_pos     <= 3'd0;
      tick_in_bit <= 8'd0;
      gap_count   <= 16'd0;
    end else begin
      state       <= state_next;
      led_ptr     <= led_ptr_next;
      byte_sel    <= byte_sel_next;
      bit_pos     <= bit_pos_next;
      tick_in_bit <= tick_in_bit_next;
      gap_count   <= gap_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_ticks       <= rgbsd_pkg::BIT_TICKS_RST;
      zero_high_ticks <= rgbsd_pkg::ZERO_HIGH_RST;
      one_high_ticks  <= rgbsd_pkg::ONE_HIGH_RST;
      gap_ticks       <= rgbsd_pkg::GAP_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rgbsd_pkg::CFG_BIT_TICKS: bit_ticks       <= cfg_data[7:0];
        rgbsd_pkg::CFG_ZERO_HIGH: zero_high_ticks <= cfg_data[7:0];
        rgbsd_pkg::CFG_ONE_HIGH:  one_high_ticks  <= cfg_data[7:0];
        rgbsd_pkg::CFG_GAP_TICKS: gap_ticks       <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Valid bits and the fill word stand in for clearing the whole RAM.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      fill_word   <= 24'd0;
    end else if (set_all) begin
      entry_valid <= '0;
      fill_word   <= {red, green, blue};
    end else if (mem_we) begin
      entry_valid[wr_addr] <= 1'b1;
    end
  end

  // The read address follows the next LED pointer, so rd_data always holds
  // the word of the LED being sent.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      colour_mem[wr_addr] <= {red, green, blue};
    end
    rd_data  <= colour_mem[led_ptr_next];
    rd_valid <= entry_valid[led_ptr_next];
  end

  rgbsd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (in_accept),
    .push_data (res),
    .full      (fifo_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign line_level = out_res.line_level;
  assign busy_res   = out_res.busy_res;
  assign frame_done = out_res.frame_done;
  assign rejected   = out_res.rejected;

  `RGBSD_ASSERT(a_refresh_starts,
    (in_accept && action == rgbsd_pkg::ACT_REFRESH && state == ST_IDLE) |=>
      (state == ST_SEND),
    "refresh from idle did not start a frame")
  `RGBSD_ASSERT(a_store_frozen_busy, busy |-> (!mem_we && !set_all),
    "colour store written during a frame")
  `RGBSD_ASSERT(a_led_ptr_range, led_ptr <= LED_LAST,
    "LED pointer beyond the strip")

endmodule

// File: tb/tb_rgb_led_strip_serial_driver_unit.sv
// ---------------------------------------------------------------------------
// Testbench for the RGB LED strip serial driver
// Drives set-colour, refresh and tick actions through the valid/stall input
// channel with random gaps, and checks every result transfer. A local model
// of the colour store, the line coder and the latch gap computes each
// expected result, and a queue holds the expectations in order. The
// timing registers are changed between phases, extremes included.
// ---------------------------------------------------------------------------
module tb_rgb_led_strip_serial_driver_unit;
  import rgbsd_pkg::*;

  // The fourth action code has no meaning in the block. It must be ignored.
  localparam action_t ACT_UNUSED = 2'd3;
  localparam int FRAME_BYTES = 3 * NUM_LEDS_DEF;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  cfg_idx_t             cfg_index = CFG_BIT_TICKS;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  action_t              action = ACT_TICK;
  logic [7:0]           led_index = '0;
  logic [7:0]           red = '0;
  logic [7:0]           green = '0;
  logic [7:0]           blue = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 line_level;
  logic                 busy_res;
  logic                 frame_done;
  logic                 rejected;

  rgb_led_strip_serial_driver_unit #(
    .NUM_LEDS(NUM_LEDS_DEF)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .led_index(led_index),
    .red(red),
    .green(green),
    .blue(blue),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .line_level(line_level),
    .busy_res(busy_res),
    .frame_done(frame_done),
    .rejected(rejected)
  );

  always #5 clk = ~clk;

  // -------------------------------------------------------------------------
  // Local model of the strip driver. Each stored pixel is {red, green, blue}.
  // -------------------------------------------------------------------------
  logic [23:0] pixel_mem [NUM_LEDS_DEF];
  logic        frame_active;
  logic        latch_active;
  logic [7:0]  bit_in_byte;
  logic [7:0]  tick_cnt;
  logic [15:0] latch_cnt;
  logic [15:0] byte_cnt;

  // Timing registers as the model sees them.
  logic [7:0]  period_cfg;
  logic [7:0]  zero_high_cfg;
  logic [7:0]  one_high_cfg;
  logic [15:0] latch_cfg;

  // Expected results in the order the block must deliver them.
  result_t     expected_line_q[$];
  int          errors = 0;

  // When set, neither side inserts gaps or stalls.
  bit          steady_flow = 1'b0;

  task automatic reset_strip_model();
    foreach (pixel_mem[i]) pixel_mem[i] = '0;
    frame_active  = 1'b0;
    latch_active  = 1'b0;
    bit_in_byte   = '0;
    tick_cnt      = '0;
    latch_cnt     = '0;
    byte_cnt      = '0;
    period_cfg    = BIT_TICKS_RST;
    zero_high_cfg = ZERO_HIGH_RST;
    one_high_cfg  = ONE_HIGH_RST;
    latch_cfg     = GAP_TICKS_RST;
  endtask

  // Applies one accepted action to the model and returns the result that
  // the block has to produce for it.
  function automatic result_t predict_strip_step(action_t act, logic [7:0] idx,
                                                 logic [7:0] r, logic [7:0] g,
                                                 logic [7:0] b);
    result_t     res;
    logic        was_busy;
    logic        bit_val;
    logic [7:0]  cur_byte;
    logic [7:0]  high_len;
    logic [7:0]  period;
    logic [15:0] latch_len;
    logic [23:0] px;
    byte_sel_t   sel;
    int unsigned led_no;
    res = '0;
    was_busy = frame_active || latch_active;
    case (act)
      ACT_SET: begin
        if (was_busy) begin
          res.rejected = 1'b1;
        end else if (idx < NUM_LEDS_DEF) begin
          pixel_mem[idx] = {r, g, b};
        end else begin
          foreach (pixel_mem[i]) pixel_mem[i] = {r, g, b};
        end
      end
      ACT_REFRESH: begin
        if (was_busy) begin
          res.rejected = 1'b1;
        end else begin
          frame_active = 1'b1;
          bit_in_byte  = '0;
          tick_cnt     = '0;
          byte_cnt     = '0;
          latch_cnt    = '0;
        end
      end
      ACT_TICK: begin
        if (frame_active) begin
          // Bytes go out per LED as green, red, blue, MSB first.
          led_no = byte_cnt / 3;
          sel = byte_sel_t'(byte_cnt % 3);
          px = pixel_mem[led_no];
          case (sel)
            SEL_GREEN: cur_byte = px[15:8];
            SEL_RED:   cur_byte = px[23:16];
            default:   cur_byte = px[7:0];
          endcase
          bit_val  = cur_byte[7 - bit_in_byte[2:0]];
          high_len = bit_val ? one_high_cfg : zero_high_cfg;
          // A period register below one still gives one-tick bits.
          period   = (period_cfg < 8'd1) ? 8'd1 : period_cfg;
          res.line_level = (tick_cnt < high_len);
          if ({1'b0, tick_cnt} + 9'd1 >= {1'b0, period}) begin
            tick_cnt = '0;
            bit_in_byte = bit_in_byte + 8'd1;
            if (bit_in_byte >= 8'd8) begin
              bit_in_byte = '0;
              byte_cnt = byte_cnt + 16'd1;
              if (byte_cnt >= FRAME_BYTES) begin
                byte_cnt     = '0;
                frame_active = 1'b0;
                latch_active = 1'b1;
                latch_cnt    = '0;
              end
            end
          end else begin
            tick_cnt = tick_cnt + 8'd1;
          end
        end else if (latch_active) begin
          // A zero gap length behaves as a single tick.
          latch_len = (latch_cfg < 16'd1) ? 16'd1 : latch_cfg;
          if ({1'b0, latch_cnt} + 17'd1 >= {1'b0, latch_len}) begin
            latch_cnt = '0;
            latch_active = 1'b0;
            res.frame_done = 1'b1;
          end else begin
            latch_cnt = latch_cnt + 16'd1;
          end
        end
      end
      default: begin
      end
    endcase
    res.busy_res = frame_active || latch_active;
    return res;
  endfunction

  // Roughly 30 percent gaps on either side, unless a steady stretch runs.
  function automatic bit roll_idle();
    return !steady_flow && ($urandom_range(99) < 30);
  endfunction

  // The receiver stalls at random. A new value is set at every falling edge.
  always @(negedge clk) begin
    out_stall <= roll_idle();
  end

  // -------------------------------------------------------------------------
  // Result checker: every result transfer is matched against the oldest
  // expectation, field by field.
  // -------------------------------------------------------------------------
  task automatic report_field(string name, logic want, logic got);
    if (want !== got) begin
      $display("%0t: mismatch on %s, expected %0b, actual %0b", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_line_q.size() == 0) begin
        $display("%0t: result transfer with nothing expected, expected none, actual %b",
                 $time, {line_level, busy_res, frame_done, rejected});
        errors++;
      end else begin
        want = expected_line_q.pop_front();
        report_field("line_level", want.line_level, line_level);
        report_field("busy_res", want.busy_res, busy_res);
        report_field("frame_done", want.frame_done, frame_done);
        report_field("rejected", want.rejected, rejected);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Shared driving tasks.
  // -------------------------------------------------------------------------

  // One input transfer. Valid may stay high from the previous transfer, and
  // it only drops at this falling edge when a random gap is taken.
  task automatic send_led_action(action_t act, logic [7:0] idx, logic [7:0] r,
                                 logic [7:0] g, logic [7:0] b);
    @(negedge clk);
    while (roll_idle()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    led_index <= idx;
    red       <= r;
    green     <= g;
    blue      <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_line_q.push_back(predict_strip_step(act, idx, r, g, b));
  endtask

  // Tick actions carry random content in the fields they do not use.
  task automatic send_ticks(int count);
    repeat (count) begin
      send_led_action(ACT_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // Stops the input and waits until every expected result has come back.
  // With one result per transfer the block is then quiet at the handshake.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_line_q.size() != 0) @(posedge clk);
  endtask

  // Register write. The model takes the new value at the same edge.
  task automatic write_timing_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      CFG_BIT_TICKS: period_cfg = value[7:0];
      CFG_ZERO_HIGH: zero_high_cfg = value[7:0];
      CFG_ONE_HIGH:  one_high_cfg = value[7:0];
      default:       latch_cfg = value;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Tests.
  // -------------------------------------------------------------------------

  // Short directed sequence on the reset timing: idle tick, unknown action,
  // single and broadcast colour writes at the index extremes, a refresh,
  // rejected actions while busy, and the first bits on the line.
  task automatic test_directed_items();
    send_led_action(ACT_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
    send_led_action(ACT_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_led_action(ACT_SET, 8'hFF, 8'hA5, 8'h5A, 8'hC3);
    send_led_action(ACT_SET, 8'(NUM_LEDS_DEF), 8'h3C, 8'h00, 8'h81);
    send_led_action(ACT_SET, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    send_led_action(ACT_SET, 8'(NUM_LEDS_DEF - 1), 8'h80, 8'h01, 8'h7F);
    send_led_action(ACT_SET, 8'h04, 8'h00, 8'hFF, 8'h00);
    send_led_action(ACT_REFRESH, 8'h00, 8'h00, 8'h00, 8'h00);
    // The frame now runs, so colour writes and refreshes bounce.
    send_led_action(ACT_SET, 8'h01, 8'h12, 8'h34, 8'h56);
    send_led_action(ACT_REFRESH, 8'h00, 8'h00, 8'h00, 8'h00);
    send_led_action(ACT_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00);
    send_ticks(13);
  endtask

  // Timing registers at their extremes, written in the middle of a frame and
  // in the middle of the latch gap. High times at or past the period, a high
  // time of zero, a zero period and a zero gap are all covered here.
  task automatic test_register_extremes();
    wait_for_results();
    write_timing_reg(CFG_BIT_TICKS, 16'h00FF);
    write_timing_reg(CFG_ZERO_HIGH, 16'h00FF);
    write_timing_reg(CFG_ONE_HIGH, 16'h0000);
    send_ticks(24);
    wait_for_results();
    write_timing_reg(CFG_BIT_TICKS, 16'h0000);
    write_timing_reg(CFG_ZERO_HIGH, 16'h00FE);
    write_timing_reg(CFG_ONE_HIGH, 16'h00FE);
    send_ticks(24);
    wait_for_results();
    write_timing_reg(CFG_BIT_TICKS, 16'h0001);
    write_timing_reg(CFG_ZERO_HIGH, 16'h0000);
    write_timing_reg(CFG_ONE_HIGH, 16'h0001);
    write_timing_reg(CFG_GAP_TICKS, 16'hFFFF);
    while (frame_active) send_ticks(1);
    send_ticks(30);
    // Shortening the gap while inside it ends the gap on the next tick.
    wait_for_results();
    write_timing_reg(CFG_GAP_TICKS, 16'h0000);
    send_ticks(3);
  endtask

  // Whole frames with random timing and random colours. A few colour writes
  // and refreshes fall into the frame and have to bounce. The first frame
  // runs with no gaps or stalls at all.
  task automatic test_random_frames(int frames);
    logic [7:0] period;
    logic [7:0] idx;
    int         roll;
    for (int f = 0; f < frames; f++) begin
      steady_flow = (f == 0);
      wait_for_results();
      period = 8'($urandom_range(0, 2));
      // The upper byte of an 8-bit register write must not matter.
      write_timing_reg(CFG_BIT_TICKS, {8'($urandom), period});
      write_timing_reg(CFG_ZERO_HIGH, {8'($urandom), 8'($urandom_range(0, period + 1))});
      write_timing_reg(CFG_ONE_HIGH, {8'($urandom), 8'($urandom_range(0, period + 1))});
      write_timing_reg(CFG_GAP_TICKS, 16'($urandom_range(0, 24)));
      repeat ($urandom_range(3, 8)) begin
        idx = ($urandom_range(99) < 80) ? 8'($urandom_range(0, NUM_LEDS_DEF - 1))
                                        : 8'($urandom);
        send_led_action(ACT_SET, idx, 8'($urandom), 8'($urandom), 8'($urandom));
      end
      send_led_action(ACT_REFRESH, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      while (frame_active || latch_active) begin
        roll = $urandom_range(99);
        if (roll < 4) begin
          send_led_action(ACT_SET, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end else if (roll < 7) begin
          send_led_action(ACT_REFRESH, 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom));
        end else if (roll < 9) begin
          send_led_action(ACT_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom));
        end else begin
          send_ticks(1);
        end
      end
    end
    steady_flow = 1'b0;
  endtask

  // Fully random actions and fields, unknown action included.
  task automatic test_random_noise(int count);
    repeat (count) begin
      send_led_action(action_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom));
    end
  endtask

  // -------------------------------------------------------------------------
  // Sequence.
  // -------------------------------------------------------------------------
  initial begin
    reset_strip_model();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_items();
    test_register_extremes();
    test_random_frames(1);
    test_random_noise(40);
    wait_for_results();
    // Keep running so that a stray extra result would still be seen.
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog well past the slowest correct run.
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule
